### rtl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared operation and status codes for the binary min-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  // Request operation codes carried on in_func.
  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_EXTRACT  = 2'd1,
    OP_DECREASE = 2'd2,
    OP_DELETE   = 2'd3
  } op_t;

  // Result status codes carried on out_status.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_RANGE   = 3'd3,
    ST_NOT_DEC = 3'd4
  } status_t;

  // Widths of the fixed result fields.
  localparam int unsigned OUT_KEY_W   = 32;
  localparam int unsigned OUT_COUNT_W = 10;

endpackage

### rtl/bmhq_ram.sv
// ----------------------------------------------------------------------------
// bmhq_ram
// Heap key store: one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned ADDR_W = 9,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a_r,
  output logic [DATA_W-1:0] rdata_b_r
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Synchronous write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two reads with registered read data.
  always_ff @(posedge clk) begin
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

endmodule

### rtl/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Binary min-heap priority queue with insert, extract-min, decrease-key and
// delete, keys held in a single on-chip memory.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; busy then stays
// high until the one result beat, which appears for exactly one cycle with
// out_valid high, and the receiver cannot stall it. Each heap level walked
// is a read state that presents an address and then a compare state that
// writes back, because every step waits on the memory's registered read data.
// A delete is a sift up followed by an extract. Rejected requests (full,
// empty, bad index, not a decrease) skip the heap walk. The key store needs
// no clearing after reset.
module binary_min_heap_queue
  import bmhq_pkg::*;
#(
  parameter int unsigned CAPACITY  = 512,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic        [1:0]  in_func,
  input  logic signed [31:0] in_key,
  input  logic        [8:0]  in_index,
  output logic               out_valid,
  output logic signed [31:0] out_value,
  output logic        [2:0]  out_status,
  output logic        [9:0]  out_count,
  output logic signed [31:0] out_min_key
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = IW + 2;
  localparam int unsigned RW = (CW > 9) ? CW : 9;
  localparam int unsigned XW = (KEY_WIDTH > OUT_KEY_W) ? KEY_WIDTH : OUT_KEY_W;

  localparam logic signed [KEY_WIDTH-1:0] MAXK = {1'b0, {(KEY_WIDTH-1){1'b1}}};
  localparam logic signed [KEY_WIDTH-1:0] MINK = {1'b1, {(KEY_WIDTH-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_UP_RD,
    S_UP_CMP,
    S_DEL_RD,
    S_LAST,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic          [CW-1:0]       count_r, count_nxt;
  logic          [IW-1:0]       pos_r, pos_nxt;
  logic signed   [KEY_WIDTH-1:0] carry_r, carry_nxt;
  logic signed   [KEY_WIDTH-1:0] value_r, value_nxt;
  logic signed   [KEY_WIDTH-1:0] root_r, root_nxt;
  status_t                      status_r, status_nxt;
  logic                         del_r, del_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic signed   [31:0]         out_value_r, out_value_nxt;
  status_t                      out_status_r, out_status_nxt;
  logic          [9:0]          out_count_r, out_count_nxt;
  logic signed   [31:0]         out_min_key_r, out_min_key_nxt;

  // Memory port signals.
  logic                         ram_we;
  logic          [IW-1:0]       ram_waddr;
  logic signed   [KEY_WIDTH-1:0] ram_wdata;
  logic          [IW-1:0]       ram_raddr_a, ram_raddr_b;
  logic signed   [KEY_WIDTH-1:0] ram_rdata_a, ram_rdata_b;

  // Request decode and width conversions.
  op_t                          op_in;
  logic signed   [XW-1:0]       key_x, value_x, root_x, maxk_x;
  logic signed   [KEY_WIDTH-1:0] key_in;
  logic          [IW-1:0]       idx_addr, last_addr, parent_addr;
  logic                         idx_bad;
  logic          [DW-1:0]       lw, rw;
  logic                         l_ok, r_ok, sel_l, sel_r;
  logic signed   [KEY_WIDTH-1:0] dn_min;

  assign op_in       = op_t'(in_func);
  assign key_x       = in_key;
  assign key_in      = key_x[KEY_WIDTH-1:0];
  assign value_x     = value_r;
  assign root_x      = root_r;
  assign maxk_x      = MAXK;
  assign idx_addr    = IW'(in_index);
  assign idx_bad     = RW'(in_index) >= RW'(count_r);
  assign last_addr   = IW'(count_r - CW'(1));
  assign parent_addr = (pos_r - IW'(1)) >> 1;

  // Children of the current position and the sift-down selection.
  assign lw     = DW'({pos_r, 1'b1});
  assign rw     = lw + DW'(1);
  assign l_ok   = lw < DW'(count_r);
  assign r_ok   = rw < DW'(count_r);
  assign sel_l  = l_ok && (ram_rdata_a < carry_r);
  assign dn_min = sel_l ? ram_rdata_a : carry_r;
  assign sel_r  = r_ok && (ram_rdata_b < dn_min);

  bmhq_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IW),
    .DATA_W (KEY_WIDTH)
  ) u_ram (
    .clk       (clk),
    .we        (ram_we),
    .waddr     (ram_waddr),
    .wdata     (ram_wdata),
    .raddr_a   (ram_raddr_a),
    .raddr_b   (ram_raddr_b),
    .rdata_a_r (ram_rdata_a),
    .rdata_b_r (ram_rdata_b)
  );

  // Next-state logic: one read-compare-write round per heap level.
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    pos_nxt         = pos_r;
    carry_nxt       = carry_r;
    value_nxt       = value_r;
    status_nxt      = status_r;
    del_nxt         = del_r;
    out_valid_nxt   = 1'b0;
    out_value_nxt   = out_value_r;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;
    out_min_key_nxt = out_min_key_r;
    ram_we          = 1'b0;
    ram_waddr       = pos_r;
    ram_wdata       = carry_r;
    ram_raddr_a     = '0;
    ram_raddr_b     = '0;

    case (state_r)
      S_IDLE: begin
        ram_raddr_a = (op_in == OP_EXTRACT) ? last_addr : idx_addr;
        if (start) begin
          carry_nxt  = key_in;
          pos_nxt    = idx_addr;
          value_nxt  = '0;
          status_nxt = ST_OK;
          del_nxt    = (op_in == OP_DELETE);
          case (op_in)
            OP_INSERT: begin
              if (count_r >= CW'(CAPACITY)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                pos_nxt   = IW'(count_r);
                count_nxt = count_r + CW'(1);
                state_nxt = S_UP_RD;
              end
            end
            OP_EXTRACT: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                value_nxt  = MAXK;
                state_nxt  = S_DONE;
              end else begin
                value_nxt = root_r;
                count_nxt = count_r - CW'(1);
                state_nxt = S_LAST;
              end
            end
            default: begin
              if (idx_bad) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_FETCH;
              end
            end
          endcase
        end
      end

      // Stored key at the requested index is on the read port.
      S_FETCH: begin
        if (del_r) begin
          value_nxt = ram_rdata_a;
          carry_nxt = MINK;
          state_nxt = S_UP_RD;
        end else if (carry_r > ram_rdata_a) begin
          status_nxt = ST_NOT_DEC;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_UP_RD;
        end
      end

      // Sift up: the root takes the carried key, otherwise read the parent.
      S_UP_RD: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = del_r ? S_DEL_RD : S_DONE;
        end else begin
          ram_raddr_a = parent_addr;
          state_nxt   = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        ram_we = 1'b1;
        if (ram_rdata_a > carry_r) begin
          ram_wdata = ram_rdata_a;
          pos_nxt   = parent_addr;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = del_r ? S_DEL_RD : S_DONE;
        end
      end

      // Delete continues as an extract of the root.
      S_DEL_RD: begin
        ram_raddr_a = last_addr;
        count_nxt   = count_r - CW'(1);
        state_nxt   = S_LAST;
      end

      // The last entry is on the read port; it restarts at the root.
      S_LAST: begin
        if (count_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          carry_nxt = ram_rdata_a;
          pos_nxt   = '0;
          state_nxt = S_DN_RD;
        end
      end

      S_DN_RD: begin
        ram_raddr_a = l_ok ? IW'(lw) : '0;
        ram_raddr_b = r_ok ? IW'(rw) : '0;
        state_nxt   = S_DN_CMP;
      end

      S_DN_CMP: begin
        ram_we = 1'b1;
        if (sel_r) begin
          ram_wdata = ram_rdata_b;
          pos_nxt   = IW'(rw);
          state_nxt = S_DN_RD;
        end else if (sel_l) begin
          ram_wdata = ram_rdata_a;
          pos_nxt   = IW'(lw);
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Present the result beat.
      S_DONE: begin
        out_valid_nxt   = 1'b1;
        out_value_nxt   = value_x[31:0];
        out_status_nxt  = status_r;
        out_count_nxt   = OUT_COUNT_W'(count_r);
        out_min_key_nxt = (count_r == '0) ? maxk_x[31:0] : root_x[31:0];
        state_nxt       = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The root is cached so that extract and the result read it without a fetch.
  assign root_nxt = (ram_we && (ram_waddr == '0)) ? ram_wdata : root_r;

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      out_valid_r   <= out_valid_nxt;
      pos_r         <= pos_nxt;
      carry_r       <= carry_nxt;
      value_r       <= value_nxt;
      root_r        <= root_nxt;
      status_r      <= status_nxt;
      del_r         <= del_nxt;
      out_value_r   <= out_value_nxt;
      out_status_r  <= out_status_nxt;
      out_count_r   <= out_count_nxt;
      out_min_key_r <= out_min_key_nxt;
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_value   = out_value_r;
  assign out_status  = out_status_r;
  assign out_count   = out_count_r;
  assign out_min_key = out_min_key_r;

  // A result beat never overlaps a request still in flight.
  a_valid_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // An accepted request raises busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // The fill count never passes the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A refused insert only happens on a full heap.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_count == OUT_COUNT_W'(CAPACITY)))
    else $error("full status with spare room");

  // An empty heap reports the largest key as its root.
  a_empty_root: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (count_r == '0)) |-> (out_min_key == maxk_x[31:0]))
    else $error("empty heap with a root key");

endmodule

### sim/binary_min_heap_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_test
// Self-checking bench for the min-heap queue. Requests are driven through the
// start/busy handshake while a local copy of the heap predicts each result
// beat. Directed cases cover the empty, full, bad-index and not-a-decrease
// paths and the key extremes. Random traffic then runs with and without
// sender gaps and finally fills the heap to capacity.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_test;
  import bmhq_pkg::*;

  localparam int CAPACITY = 512;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

  // One predicted result beat.
  typedef struct {
    logic signed [31:0] value;
    status_t            status;
    logic        [9:0]  count;
    logic signed [31:0] min_key;
  } heap_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic        [1:0]  in_func = OP_INSERT;
  logic signed [31:0] in_key = '0;
  logic        [8:0]  in_index = '0;
  logic               out_valid;
  logic signed [31:0] out_value;
  logic        [2:0]  out_status;
  logic        [9:0]  out_count;
  logic signed [31:0] out_min_key;

  // Local heap image and the results still owed by the block.
  logic signed [31:0] heap_keys [CAPACITY];
  int                 model_count = 0;
  heap_result_t       pending_results[$];
  heap_result_t       oldest_result;

  int fail_count = 0;
  int sender_idle_pct = 0;
  int quiet_cycles = 0;

  binary_min_heap_queue u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_func    (in_func),
    .in_key     (in_key),
    .in_index   (in_index),
    .out_valid  (out_valid),
    .out_value  (out_value),
    .out_status (out_status),
    .out_count  (out_count),
    .out_min_key(out_min_key)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void swap_keys(int a, int b);
    logic signed [31:0] held;
    held = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = held;
  endfunction

  // Moves an entry toward the root while its parent is strictly larger.
  function automatic void sift_key_up(int pos);
    int parent;
    while (pos != 0) begin
      parent = (pos - 1) / 2;
      if (heap_keys[parent] <= heap_keys[pos]) break;
      swap_keys(pos, parent);
      pos = parent;
    end
  endfunction

  // Moves an entry down; ties keep the parent and then the left child.
  function automatic void sift_key_down(int pos);
    int left;
    int right;
    int least;
    forever begin
      left = 2 * pos + 1;
      right = left + 1;
      least = pos;
      if (left < model_count && heap_keys[left] < heap_keys[least]) least = left;
      if (right < model_count && heap_keys[right] < heap_keys[least]) least = right;
      if (least == pos) break;
      swap_keys(pos, least);
      pos = least;
    end
  endfunction

  function automatic logic signed [31:0] pop_root();
    logic signed [31:0] root;
    root = heap_keys[0];
    model_count--;
    if (model_count > 0) begin
      heap_keys[0] = heap_keys[model_count];
      sift_key_down(0);
    end
    return root;
  endfunction

  // Applies one accepted request to the local heap and returns its result.
  function automatic heap_result_t predict_heap_request(op_t func, logic signed [31:0] key,
                                                        logic [8:0] index);
    heap_result_t res;
    res.value = '0;
    res.status = ST_OK;
    case (func)
      OP_INSERT: begin
        if (model_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          heap_keys[model_count] = key;
          model_count++;
          sift_key_up(model_count - 1);
        end
      end
      OP_EXTRACT: begin
        if (model_count == 0) begin
          res.status = ST_EMPTY;
          res.value = KEY_MAX;
        end else begin
          res.value = pop_root();
        end
      end
      default: begin
        if (int'(index) >= model_count) begin
          res.status = ST_RANGE;
        end else if (func == OP_DECREASE) begin
          if (key > heap_keys[index]) begin
            res.status = ST_NOT_DEC;
          end else begin
            heap_keys[index] = key;
            sift_key_up(int'(index));
          end
        end else begin
          // Delete: force the entry to the smallest key, then take the root.
          res.value = heap_keys[index];
          heap_keys[index] = KEY_MIN;
          sift_key_up(int'(index));
          void'(pop_root());
        end
      end
    endcase
    res.count = model_count[9:0];
    res.min_key = (model_count > 0) ? heap_keys[0] : KEY_MAX;
    return res;
  endfunction

  // ------------------------------------------------------------------ checker

  task automatic note_failure(string text);
    fail_count++;
    if (fail_count <= 10) $display("%s", text);
  endtask

  // Every result beat is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf({"%0t: result beat with nothing pending: value=%0d ",
                                "status=%0d count=%0d min_key=%0d"},
                               $realtime, out_value, out_status, out_count, out_min_key));
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_value !== oldest_result.value || out_status !== oldest_result.status ||
            out_count !== oldest_result.count || out_min_key !== oldest_result.min_key) begin
          note_failure($sformatf({"%0t: mismatch: expected value=%0d status=%0d count=%0d ",
                                  "min_key=%0d, got value=%0d status=%0d count=%0d min_key=%0d"},
                                 $realtime, oldest_result.value, oldest_result.status,
                                 oldest_result.count, oldest_result.min_key,
                                 out_value, out_status, out_count, out_min_key));
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ----------------------------------------------------------------- stimulus

  // Sends one request beat, with an optional gap first, and records its result.
  task automatic send_request(op_t func, logic signed [31:0] key, logic [8:0] index);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(($urandom_range(3) == 0) ? 60 : 8, 1)) @(posedge clk);
    end
    in_func <= func;
    in_key <= key;
    in_index <= index;
    start <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_results.push_back(predict_heap_request(func, key, index));
  endtask

  // Keys lean on the extremes and on small values that produce ties.
  function automatic logic signed [31:0] random_key();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return KEY_MIN;
    if (pick == 1) return KEY_MAX;
    if (pick < 4) return $signed(32'($urandom_range(16))) - 8;
    return $urandom;
  endfunction

  // Mostly a valid position, sometimes anywhere in the index range.
  function automatic logic [8:0] random_index();
    if (model_count > 0 && $urandom_range(9) != 0) return 9'($urandom_range(model_count - 1));
    return 9'($urandom_range(511));
  endfunction

  // New key for a decrease: smaller, equal, larger or unrelated.
  function automatic logic signed [31:0] decrease_key_for(logic [8:0] index);
    longint stored;
    longint wanted;
    int pick;
    if (int'(index) >= model_count) return random_key();
    stored = heap_keys[index];
    pick = $urandom_range(99);
    if (pick < 50) begin
      wanted = stored - (longint'($urandom) >> $urandom_range(31));
      if (wanted < longint'(KEY_MIN)) wanted = KEY_MIN;
    end else if (pick < 65) begin
      wanted = stored;
    end else if (pick < 85) begin
      wanted = stored + 1 + (longint'($urandom) >> $urandom_range(31));
      if (wanted > longint'(KEY_MAX)) wanted = KEY_MAX;
    end else begin
      return random_key();
    end
    return wanted[31:0];
  endfunction

  // Issues one random request with the given operation mix.
  task automatic send_random_request(int insert_pct, int extract_pct, int decrease_pct);
    int pick;
    logic [8:0] index;
    pick = $urandom_range(99);
    index = random_index();
    if (pick < insert_pct) begin
      send_request(OP_INSERT, random_key(), 9'($urandom_range(511)));
    end else if (pick < insert_pct + extract_pct) begin
      send_request(OP_EXTRACT, random_key(), 9'($urandom_range(511)));
    end else if (pick < insert_pct + extract_pct + decrease_pct) begin
      send_request(OP_DECREASE, decrease_key_for(index), index);
    end else begin
      send_request(OP_DELETE, random_key(), index);
    end
  endtask

  // ------------------------------------------------------------------- tests

  // Extract, delete and decrease against an empty heap.
  task automatic test_empty_requests();
    send_request(OP_EXTRACT, 32'sd0, 9'd0);
    send_request(OP_DELETE, 32'sd0, 9'd0);
    send_request(OP_DECREASE, 32'sd5, 9'd0);
  endtask

  // Inserts key extremes and duplicates, then extracts the two smallest.
  task automatic test_insert_extract_order();
    send_request(OP_INSERT, KEY_MAX, 9'd0);
    send_request(OP_INSERT, KEY_MIN, 9'd511);
    send_request(OP_INSERT, 32'sd0, 9'd0);
    send_request(OP_INSERT, -32'sd1, 9'd0);
    send_request(OP_INSERT, 32'sd7, 9'd0);
    send_request(OP_INSERT, 32'sd7, 9'd0);
    send_request(OP_EXTRACT, 32'sd0, 9'd0);
    send_request(OP_EXTRACT, 32'sd0, 9'd0);
  endtask

  // Larger, equal and smaller keys, then a position one past the end.
  task automatic test_decrease_key();
    send_request(OP_DECREASE, KEY_MAX, 9'd0);
    send_request(OP_DECREASE, heap_keys[model_count - 1], 9'(model_count - 1));
    send_request(OP_DECREASE, KEY_MIN, 9'(model_count - 1));
    send_request(OP_DECREASE, 32'sd1, 9'(model_count));
  endtask

  // Delete with a tied smallest key already present, and a bad position.
  task automatic test_delete_entry();
    send_request(OP_INSERT, KEY_MIN, 9'd0);
    send_request(OP_DELETE, 32'sd0, 9'(model_count - 1));
    send_request(OP_DELETE, 32'sd0, 9'd0);
    send_request(OP_DELETE, 32'sd0, 9'd511);
  endtask

  // Mixed traffic on a small heap with the given sender gap rate.
  task automatic test_random_traffic(int idle_pct, int items);
    sender_idle_pct = idle_pct;
    repeat (items) begin
      send_random_request((model_count < 20) ? 45 : 30, 25, 18);
    end
  endtask

  // Fills the heap, knocks on the full limit and works near the top index.
  task automatic test_full_heap();
    sender_idle_pct = 37;
    while (model_count < CAPACITY) begin
      send_request(OP_INSERT, random_key(), 9'($urandom_range(511)));
    end
    repeat (3) send_request(OP_INSERT, random_key(), 9'($urandom_range(511)));
    repeat (40) begin
      if ($urandom_range(2) == 0) begin
        send_request(($urandom_range(1) == 0) ? OP_DELETE : OP_DECREASE,
                     KEY_MIN, 9'(model_count - 1));
      end else begin
        send_random_request(25, 15, 30);
      end
    end
  endtask

  // --------------------------------------------------------------- main flow

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_requests();
    test_insert_extract_order();
    test_decrease_key();
    test_delete_entry();
    test_random_traffic(0, 70);
    test_random_traffic(58, 70);
    test_random_traffic(37, 70);
    test_full_heap();

    // Let the last beats come back, then watch for stray ones.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) note_failure("results still pending at end of run");

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
